@@ src/tap_to_note_greedy_matcher_defines.svh @@
// Assertion macros used by the matcher engine.
`ifndef TAP_TO_NOTE_GREEDY_MATCHER_DEFINES_SVH
`define TAP_TO_NOTE_GREEDY_MATCHER_DEFINES_SVH

// Same-cycle implication, checked on clk with rst_n low disabling.
`define TNM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk with rst_n low disabling.
`define TNM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tnm_pkg.sv @@
// Types and constants shared by the tap-to-note matcher modules.
package tnm_pkg;

  localparam int POS_W   = 24;
  localparam int TOL_W   = 24;
  localparam int TOT_W   = 16;
  localparam int NIDX_W  = 6;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_TAP    = 2'd1;
  localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam logic [TOL_W-1:0] TOL_RESET = 24'd100;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_TAP,
    CMD_FINISH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [POS_W-1:0]  pos;
  } cmd_t;

  typedef struct packed {
    logic              kind;
    logic              hit;
    logic [NIDX_W-1:0] note_index;
    logic              found;
    logic [POS_W-1:0]  distance;
    logic [TOT_W-1:0]  correct_count;
    logic [TOT_W-1:0]  wrong_count;
    logic              overflow;
  } res_t;

endpackage

@@ src/tnm_front.sv @@
// Input front end: decode the operation code and pass commands to the queue.
module tnm_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tnm_pkg::OP_W-1:0]     in_op,
  input  logic [tnm_pkg::POS_W-1:0]    in_pos,
  output logic                         push_valid,
  input  logic                         push_ready,
  output tnm_pkg::cmd_t                push_cmd
);

  logic known;

  always_comb begin
    known         = 1'b1;
    push_cmd.pos  = in_pos;
    push_cmd.kind = tnm_pkg::CMD_LOAD;
    unique case (in_op)
      tnm_pkg::OP_LOAD:   push_cmd.kind = tnm_pkg::CMD_LOAD;
      tnm_pkg::OP_TAP:    push_cmd.kind = tnm_pkg::CMD_TAP;
      tnm_pkg::OP_FINISH: push_cmd.kind = tnm_pkg::CMD_FINISH;
      default:            known = 1'b0;
    endcase
  end

  // drop unused codes: accept without pushing
  assign in_ready   = push_ready;
  assign push_valid = in_valid && known;

endmodule

@@ src/tnm_fifo.sv @@
// Short command queue between the front end and the matching engine.
module tnm_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  tnm_pkg::cmd_t  push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tnm_pkg::cmd_t  pop_cmd
);

  tnm_pkg::cmd_t                    slot_r [tnm_pkg::FIFO_DEPTH];
  logic [tnm_pkg::FIFO_PTR_W-1:0]   wr_ptr_r;
  logic [tnm_pkg::FIFO_PTR_W-1:0]   rd_ptr_r;
  logic [tnm_pkg::FIFO_CNT_W-1:0]   cnt_r;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (cnt_r != tnm_pkg::FIFO_CNT_W'(tnm_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_cmd    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

@@ src/tnm_engine.sv @@
// Matching engine: note table, nearest-note scan, counters and result register.
`include "tap_to_note_greedy_matcher_defines.svh"

module tnm_engine #(
  parameter int MAX_NOTES = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  tnm_pkg::cmd_t               cmd,
  input  logic [tnm_pkg::TOL_W-1:0]   tol,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tnm_pkg::res_t               out_res
);

  localparam int IDX_W = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int CNT_W = $clog2(MAX_NOTES + 1);
  localparam int PW    = tnm_pkg::POS_W;
  localparam int TW    = tnm_pkg::TOT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_EMIT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  logic [TW-1:0]      tap_tot_r;
  logic [TW-1:0]      hit_tot_r;

  logic [PW:0]        mem [MAX_NOTES];
  logic [PW:0]        rd_data_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [PW:0]        mem_wd;
  logic [IDX_W-1:0]   mem_ra;

  logic [CNT_W-1:0]   iss_r;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [PW-1:0]      tap_r;
  logic               best_fnd_r;
  logic [IDX_W-1:0]   best_idx_r;
  logic [PW-1:0]      best_dist_r;
  logic [PW-1:0]      best_pos_r;

  tnm_pkg::res_t      res_r;
  tnm_pkg::res_t      out_res_r;
  logic               out_valid_r;

  logic               issuing;
  logic               room;
  logic               emit_go;
  logic [PW:0]        diff_tn;
  logic [PW:0]        diff_nt;
  logic [PW-1:0]      cand_dist;
  logic               better;
  logic               hit;
  logic [TW-1:0]      tap_tot_inc;
  logic [TW-1:0]      hit_tot_inc;
  logic [31:0]        idx_ext;

  assign cmd_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign room      = (cnt_r < CNT_W'(MAX_NOTES));
  assign issuing   = (state_r == ST_SCAN) && (iss_r < cnt_r);
  assign mem_ra    = iss_r[IDX_W-1:0];
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  assign diff_tn   = {tap_r[PW-1], tap_r} - {rd_data_r[PW-1], rd_data_r[PW-1:0]};
  assign diff_nt   = {rd_data_r[PW-1], rd_data_r[PW-1:0]} - {tap_r[PW-1], tap_r};
  assign cand_dist = diff_tn[PW] ? diff_nt[PW-1:0] : diff_tn[PW-1:0];
  assign better    = rd_vld_r && !rd_data_r[PW] &&
                     (!best_fnd_r || (cand_dist < best_dist_r));

  assign hit         = best_fnd_r && (best_dist_r <= tol);
  assign tap_tot_inc = (tap_tot_r == {TW{1'b1}}) ? tap_tot_r : tap_tot_r + 1'b1;
  assign hit_tot_inc = (hit_tot_r == {TW{1'b1}}) ? hit_tot_r : hit_tot_r + 1'b1;
  assign idx_ext     = 32'(best_idx_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = cnt_r[IDX_W-1:0];
    mem_wd = {1'b0, cmd.pos};
    if (state_r == ST_IDLE && cmd_valid && cmd.kind == tnm_pkg::CMD_LOAD && room) begin
      mem_we = 1'b1;
    end else if (state_r == ST_RESOLVE && hit) begin
      mem_we = 1'b1;
      mem_wa = best_idx_r;
      mem_wd = {1'b1, best_pos_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      tap_tot_r   <= '0;
      hit_tot_r   <= '0;
      rd_vld_r    <= 1'b0;
      iss_r       <= '0;
      best_fnd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              tnm_pkg::CMD_LOAD: begin
                if (room) begin
                  cnt_r <= cnt_r + 1'b1;
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              tnm_pkg::CMD_TAP: begin
                tap_r      <= cmd.pos;
                iss_r      <= '0;
                rd_vld_r   <= 1'b0;
                best_fnd_r <= 1'b0;
                state_r    <= ST_SCAN;
              end
              tnm_pkg::CMD_FINISH: begin
                res_r     <= '{kind: 1'b1, hit: 1'b0, note_index: '0, found: 1'b0,
                               distance: '0, correct_count: hit_tot_r,
                               wrong_count: tap_tot_r - hit_tot_r, overflow: ovf_r};
                cnt_r     <= '0;
                ovf_r     <= 1'b0;
                tap_tot_r <= '0;
                hit_tot_r <= '0;
                state_r   <= ST_EMIT;
              end
              default: ;
            endcase
          end
        end
        ST_SCAN: begin
          rd_vld_r <= issuing;
          rd_idx_r <= iss_r[IDX_W-1:0];
          if (issuing) begin
            iss_r <= iss_r + 1'b1;
          end
          if (better) begin
            best_fnd_r  <= 1'b1;
            best_idx_r  <= rd_idx_r;
            best_dist_r <= cand_dist;
            best_pos_r  <= rd_data_r[PW-1:0];
          end
          if (!issuing && !rd_vld_r) begin
            state_r <= ST_RESOLVE;
          end
        end
        ST_RESOLVE: begin
          tap_tot_r <= tap_tot_inc;
          if (hit) begin
            hit_tot_r <= hit_tot_inc;
          end
          res_r.kind          <= 1'b0;
          res_r.hit           <= hit;
          res_r.found         <= best_fnd_r;
          res_r.note_index    <= best_fnd_r ? idx_ext[tnm_pkg::NIDX_W-1:0] : '0;
          res_r.distance      <= best_fnd_r ? best_dist_r : '0;
          res_r.correct_count <= hit ? hit_tot_inc : hit_tot_r;
          res_r.wrong_count   <= tap_tot_inc - (hit ? hit_tot_inc : hit_tot_r);
          res_r.overflow      <= ovf_r;
          state_r             <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_res_r <= res_r;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `TNM_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_NOTES), "note count beyond table size")
  `TNM_ASSERT_IMP(a_hit_found, out_valid_r && out_res_r.hit,
    out_res_r.found && !out_res_r.kind, "hit without a found note")
  `TNM_ASSERT_NXT(a_finish_clear,
    state_r == ST_IDLE && cmd_valid && cmd.kind == tnm_pkg::CMD_FINISH,
    cnt_r == '0 && tap_tot_r == '0 && state_r == ST_EMIT, "finish did not clear")

endmodule

@@ src/tap_to_note_greedy_matcher.sv @@
// Tap-to-note greedy matcher top level.
//
// Input stream (in_*): one transfer per item. tdata carries the operation
// (load note, tap, finish) and a signed position. Unused operation codes are
// taken and dropped. Loads beyond the table size are dropped and set overflow.
// Output stream (out_*): one transfer per tap (tuser 0) and per finish
// (tuser 1, summary with correct and wrong counts); loads give none.
// Config channel (cfg_*): writes the 24-bit tolerance; write only when idle.
// A tap scans the loaded notes one entry per cycle through the read port of
// the note memory and then resolves and emits its result; loads need no scan
// and a finish goes straight to emit. The queue registers each command ahead
// of the engine.
// Commands queue up to four deep ahead of the engine, so the input keeps
// taking items while a tap scans or a result waits.
// When the receiver stalls, the result holds in the output register and the
// engine waits; the queue then fills and in_tready drops.
// Reset clears the counters, note count, overflow flag and queue and sets
// the tolerance to 100; the note table needs no clearing.
module tap_to_note_greedy_matcher #(
  parameter int MAX_NOTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // operation[1:0], position[25:2], zero[31:26]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // hit[0], note_index[6:1], found[7], distance[31:8],
                                  // correct_count[47:32], wrong_count[63:48],
                                  // overflow[64], zero[71:65]
  output logic [0:0]  out_tuser,  // kind[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  logic [tnm_pkg::TOL_W-1:0] tol_r;
  logic                      push_valid;
  logic                      push_ready;
  tnm_pkg::cmd_t             push_cmd;
  logic                      pop_valid;
  logic                      pop_ready;
  tnm_pkg::cmd_t             pop_cmd;
  tnm_pkg::res_t             res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= tnm_pkg::TOL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tol_r <= cfg_data;
    end
  end

  tnm_front u_front (
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_op      (in_tdata[1:0]),
    .in_pos     (in_tdata[25:2]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tnm_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  tnm_engine #(
    .MAX_NOTES (MAX_NOTES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .tol       (tol_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {7'd0, res.overflow, res.wrong_count, res.correct_count,
                      res.distance, res.found, res.note_index, res.hit};

endmodule

@@ bench/tap_to_note_greedy_matcher_test.sv @@
// Self-checking stream testbench for the tap-to-note greedy matcher.
module tap_to_note_greedy_matcher_test;

  localparam int NOTE_SLOTS = 64;
  localparam logic [tnm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int RANDOM_ITEMS_PER_PHASE = 100;

  typedef struct {
    logic [tnm_pkg::OP_W-1:0]  op;
    logic [tnm_pkg::POS_W-1:0] pos;
  } song_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [23:0] cfg_data = '0;

  song_item_t    song_items[$];
  tnm_pkg::res_t due_results[$];
  song_item_t    item_on_bus;
  logic          in_fired = 1'b0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            scripted_count = 0;
  int            mismatches = 0;
  int            cycle_count = 0;

  logic [tnm_pkg::POS_W-1:0] note_pos[NOTE_SLOTS];
  bit                        note_matched[NOTE_SLOTS];
  int                        note_count = 0;
  logic [tnm_pkg::TOT_W-1:0] tap_count = '0;
  logic [tnm_pkg::TOT_W-1:0] hit_count = '0;
  logic                      overflow_seen = 1'b0;
  logic [tnm_pkg::TOL_W-1:0] tolerance = tnm_pkg::TOL_RESET;

  tap_to_note_greedy_matcher #(
    .MAX_NOTES(NOTE_SLOTS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  task automatic score_item(input song_item_t it);
    tnm_pkg::res_t r;
    int   tap_v;
    int   d;
    int   best_d;
    int   best_i;
    int   i;
    bit   found;
    r = '0;
    found = 1'b0;
    best_d = 0;
    best_i = 0;
    case (it.op)
      tnm_pkg::OP_LOAD: begin
        if (note_count < NOTE_SLOTS) begin
          note_pos[note_count] = it.pos;
          note_matched[note_count] = 1'b0;
          note_count++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      tnm_pkg::OP_TAP: begin
        tap_v = $signed(it.pos);
        for (i = 0; i < note_count; i++) begin
          if (!note_matched[i]) begin
            d = tap_v - int'($signed(note_pos[i]));
            if (d < 0) d = -d;
            if (!found || d < best_d) begin
              found = 1'b1;
              best_d = d;
              best_i = i;
            end
          end
        end
        if (tap_count != 16'hFFFF) tap_count++;
        if (found && best_d <= int'(tolerance)) begin
          r.hit = 1'b1;
          note_matched[best_i] = 1'b1;
          if (hit_count != 16'hFFFF) hit_count++;
        end
        r.kind = 1'b0;
        r.found = found;
        r.note_index = best_i[tnm_pkg::NIDX_W-1:0];
        r.distance = best_d[tnm_pkg::POS_W-1:0];
        r.correct_count = hit_count;
        r.wrong_count = tap_count - hit_count;
        r.overflow = overflow_seen;
        due_results.push_back(r);
      end
      tnm_pkg::OP_FINISH: begin
        r.kind = 1'b1;
        r.correct_count = hit_count;
        r.wrong_count = tap_count - hit_count;
        r.overflow = overflow_seen;
        due_results.push_back(r);
        note_count = 0;
        tap_count = '0;
        hit_count = '0;
        overflow_seen = 1'b0;
        for (i = 0; i < NOTE_SLOTS; i++) note_matched[i] = 1'b0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    tnm_pkg::res_t got;
    tnm_pkg::res_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tap_to_note_greedy_matcher_test: done, errors");
      $finish;
    end
    in_fired <= in_tvalid && in_tready;
    if (rst_n && cfg_valid && cfg_ready) tolerance = cfg_data;
    if (rst_n && in_tvalid && in_tready) score_item(item_on_bus);
    if (rst_n && out_tvalid && out_tready) begin
      got = '0;
      got.kind = out_tuser[0];
      got.hit = out_tdata[0];
      got.note_index = out_tdata[6:1];
      got.found = out_tdata[7];
      got.distance = out_tdata[31:8];
      got.correct_count = out_tdata[47:32];
      got.wrong_count = out_tdata[63:48];
      got.overflow = out_tdata[64];
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d hit %0d idx %0d found %0d dist %0d",
                   got.kind, got.hit, got.note_index, got.found, got.distance);
      end else begin
        want = due_results.pop_front();
        if (got.kind !== want.kind || got.hit !== want.hit ||
            got.note_index !== want.note_index || got.found !== want.found ||
            got.distance !== want.distance || got.correct_count !== want.correct_count ||
            got.wrong_count !== want.wrong_count || got.overflow !== want.overflow) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("want: kind %0d hit %0d idx %0d fnd %0d dist %0d ok %0d bad %0d ovf %0d",
                     want.kind, want.hit, want.note_index, want.found, want.distance,
                     want.correct_count, want.wrong_count, want.overflow);
            $display("got:  kind %0d hit %0d idx %0d fnd %0d dist %0d ok %0d bad %0d ovf %0d",
                     got.kind, got.hit, got.note_index, got.found, got.distance,
                     got.correct_count, got.wrong_count, got.overflow);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    song_item_t nxt;
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fired) begin
      if (song_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = song_items.pop_front();
        item_on_bus <= nxt;
        in_tdata <= {6'b0, nxt.pos, nxt.op};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic add_item(input logic [tnm_pkg::OP_W-1:0] op,
                          input logic [tnm_pkg::POS_W-1:0] pos);
    song_item_t it;
    it.op = op;
    it.pos = pos;
    song_items.push_back(it);
    if (op != OP_UNUSED) scripted_count++;
  endtask

  task automatic queue_song();
    int                        roll;
    int                        n_notes;
    int                        n_taps;
    int                        span;
    int                        off;
    int                        k;
    logic [tnm_pkg::POS_W-1:0] base;
    logic [tnm_pkg::POS_W-1:0] p;
    logic [tnm_pkg::POS_W-1:0] notes[$];
    roll = $urandom_range(99);
    n_notes = (roll < 10) ? 0 : (roll < 90) ? $urandom_range(1, 12) : $urandom_range(60, 70);
    base = 24'($urandom);
    case ($urandom_range(3))
      0: span = 2;
      1: span = 150;
      2: span = 4000;
      default: span = 1 << 23;
    endcase
    for (k = 0; k < n_notes; k++) begin
      if (k > 0 && $urandom_range(7) == 0) p = notes[$];
      else p = base + 24'($urandom_range(0, 2 * span));
      notes.push_back(p);
      add_item(tnm_pkg::OP_LOAD, p);
      if ($urandom_range(19) == 0) add_item(OP_UNUSED, 24'($urandom));
    end
    n_taps = $urandom_range(0, n_notes + 3);
    for (k = 0; k < n_taps; k++) begin
      if (notes.size() != 0 && $urandom_range(9) != 0) begin
        off = $urandom_range(0, 2 * span);
        off = off - span;
        p = notes[$urandom_range(notes.size() - 1)] + 24'(off);
      end else begin
        p = 24'($urandom);
      end
      add_item(tnm_pkg::OP_TAP, p);
      if ($urandom_range(19) == 0) add_item(OP_UNUSED, 24'($urandom));
    end
    if ($urandom_range(9) != 0) add_item(tnm_pkg::OP_FINISH, 24'($urandom));
  endtask

  task automatic wait_idle();
    while (song_items.size() != 0 || in_tvalid) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [tnm_pkg::TOL_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int phase;
    int target;
    logic [tnm_pkg::TOL_W-1:0] tol_plan[8];
    tol_plan = '{24'd0, 24'hFFFFFF, 24'd1000, 24'd0, 24'd5, 24'hFFFFFF, 24'd0, 24'd0};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_item(tnm_pkg::OP_TAP, 24'h000000);
    add_item(tnm_pkg::OP_LOAD, 24'h800000);
    add_item(tnm_pkg::OP_LOAD, 24'h7FFFFF);
    add_item(tnm_pkg::OP_TAP, 24'h7FFFFF);
    add_item(tnm_pkg::OP_TAP, 24'h800000);
    add_item(tnm_pkg::OP_TAP, 24'h000000);
    add_item(tnm_pkg::OP_LOAD, 24'd100);
    add_item(tnm_pkg::OP_LOAD, 24'd300);
    add_item(tnm_pkg::OP_TAP, 24'd200);
    add_item(tnm_pkg::OP_TAP, 24'd200);
    add_item(tnm_pkg::OP_LOAD, 24'd5000);
    add_item(tnm_pkg::OP_TAP, 24'd5101);
    add_item(OP_UNUSED, 24'h123456);
    add_item(tnm_pkg::OP_FINISH, 24'hFFFFFF);
    add_item(tnm_pkg::OP_LOAD, 24'h800000);
    add_item(tnm_pkg::OP_TAP, 24'h7FFFFF);
    add_item(tnm_pkg::OP_FINISH, 24'h000000);
    wait_idle();

    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      write_tolerance((phase == 3 || phase == 7) ? 24'($urandom) : tol_plan[phase]);
      target = scripted_count + RANDOM_ITEMS_PER_PHASE;
      while (scripted_count < target) queue_song();
      wait_idle();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_tolerance(24'd100);
    add_item(tnm_pkg::OP_LOAD, 24'd1000);
    add_item(tnm_pkg::OP_LOAD, 24'd2000);
    add_item(tnm_pkg::OP_TAP, 24'd1000);
    add_item(tnm_pkg::OP_TAP, 24'd2050);
    add_item(tnm_pkg::OP_FINISH, 24'd0);
    add_item(tnm_pkg::OP_TAP, 24'd0);
    add_item(tnm_pkg::OP_FINISH, 24'd0);
    wait_idle();

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tap_to_note_greedy_matcher_test: done, clean");
    end else begin
      $display("tap_to_note_greedy_matcher_test: done, errors");
    end
    $finish;
  end

endmodule
